FILE: src/epb_pkg.sv
// ----------------------------------------------------------------------------
// epb_pkg
// Shared types and constants for the edge partition binner.
// ----------------------------------------------------------------------------
package epb_pkg;

    localparam int TOTAL_PARTS             = 16;
    localparam int VERTICES_PER_PARTITION  = 65536;
    localparam int VERTICES_PER_SRC_BUFFER = 4096;

    localparam int VERTEX_W    = 31;
    localparam int WORD_W      = 32;
    localparam int FP_W        = 4;
    localparam int OUT_PART_W  = 4;
    localparam int ALIGN_EDGES = 8;
    localparam int ALIGN_W     = $clog2(ALIGN_EDGES);

    localparam int PART_SHIFT = $clog2(VERTICES_PER_PARTITION);
    localparam int BUF_SHIFT  = $clog2(VERTICES_PER_SRC_BUFFER);
    localparam int PART_IDX_W = (TOTAL_PARTS > 1) ? $clog2(TOTAL_PARTS) : 1;
    localparam int BUF_W      = VERTEX_W - BUF_SHIFT;

    localparam logic [VERTEX_W-1:0] END_FLAG_RESET = '1;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 104;

    typedef enum logic [0:0] {
        CMD_EDGE  = 1'b0,
        CMD_FLUSH = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        OP_EDGE    = 2'd0,
        OP_FLUSH   = 2'd1,
        OP_BAD_DST = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_EDGE    = 2'd0,
        KIND_ALIGN   = 2'd1,
        KIND_TERM    = 2'd2,
        KIND_BAD_DST = 2'd3
    } kind_t;

    typedef struct packed {
        op_t                   op;
        logic [PART_IDX_W-1:0] part;
        logic [BUF_W-1:0]      src_buf;
        logic [VERTEX_W-1:0]   src;
        logic [VERTEX_W-1:0]   dst;
    } bin_op_t;

endpackage

FILE: src/epb_front.sv
// ----------------------------------------------------------------------------
// epb_front
// Accepts input words and classifies them into queue entries.
// ----------------------------------------------------------------------------
module epb_front
    import epb_pkg::*;
(
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                command,
    input  logic [VERTEX_W-1:0] src_vertex,
    input  logic [VERTEX_W-1:0] dst_vertex,
    input  logic [FP_W-1:0]     flush_partition,
    output logic                push_valid,
    input  logic                push_ready,
    output bin_op_t             push_data
);

    logic [VERTEX_W-1:0] part_full;
    logic                dst_bad;
    logic                fp_bad;

    assign part_full = dst_vertex >> PART_SHIFT;
    assign dst_bad   = (part_full >= VERTEX_W'(TOTAL_PARTS));
    assign fp_bad    = (32'(flush_partition) >= 32'(TOTAL_PARTS));

    always_comb
    begin
        push_data.src     = src_vertex;
        push_data.dst     = dst_vertex;
        push_data.src_buf = src_vertex[VERTEX_W-1:BUF_SHIFT];
        push_data.part    = PART_IDX_W'(part_full);
        push_data.op      = OP_EDGE;
        push_valid        = s_valid;
        if (cmd_t'(command) == CMD_FLUSH)
        begin
            push_data.op   = OP_FLUSH;
            push_data.part = PART_IDX_W'(flush_partition);
            // A flush of a partition that does not exist has no effect at all.
            push_valid     = s_valid && !fp_bad;
        end
        else if (dst_bad)
        begin
            push_data.op = OP_BAD_DST;
        end
    end

    assign s_ready = push_ready;

endmodule

FILE: src/epb_fifo.sv
// ----------------------------------------------------------------------------
// epb_fifo
// Short queue between the classifying front and the emitting back.
// ----------------------------------------------------------------------------
module epb_fifo
    import epb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_ready,
    input  bin_op_t push_data,
    output logic    pop_valid,
    input  logic    pop,
    output bin_op_t pop_data
);

    bin_op_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_W:0]    fill_reg, fill_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (fill_reg != (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        fill_next = fill_reg + (FIFO_PTR_W+1)'(do_push) - (FIFO_PTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/epb_back.sv
// ----------------------------------------------------------------------------
// epb_back
// Partition table and result emitter, one result word per cycle unless stalled.
// ----------------------------------------------------------------------------
module epb_back
    import epb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [VERTEX_W-1:0] cfg_wdata,
    input  logic                op_valid,
    output logic                op_pop,
    input  bin_op_t             op,
    output logic                m_valid,
    input  logic                m_ready,
    output kind_t               kind,
    output logic [OUT_PART_W-1:0] partition,
    output logic [WORD_W-1:0]   edge_src_word,
    output logic [WORD_W-1:0]   edge_dst_word,
    output logic [WORD_W-1:0]   edge_count,
    output logic                last
);

    logic [VERTEX_W-1:0] end_flag_reg;

    logic [WORD_W-1:0]   cnt_reg      [TOTAL_PARTS];
    logic [VERTEX_W-1:0] last_src_reg [TOTAL_PARTS];
    logic [BUF_W-1:0]    buf_idx_reg  [TOTAL_PARTS];

    logic                  out_valid_reg;
    kind_t                 kind_reg, kind_next;
    logic [OUT_PART_W-1:0] part_reg, part_next;
    logic [WORD_W-1:0]     src_word_reg, src_word_next;
    logic [WORD_W-1:0]     dst_word_reg, dst_word_next;
    logic [WORD_W-1:0]     count_reg, count_next;
    logic                  last_reg, last_next;

    logic                  slot_free;
    logic                  emit;
    logic                  cnt_we;
    logic                  edge_we;
    logic [WORD_W-1:0]     cnt_cur;
    logic [WORD_W-1:0]     cnt_inc;
    logic [VERTEX_W-1:0]   src_cur;
    logic [BUF_W-1:0]      buf_cur;
    logic [WORD_W-1:0]     pad_dst;

    assign slot_free = !out_valid_reg || m_ready;
    assign cnt_cur   = cnt_reg[op.part];
    assign src_cur   = last_src_reg[op.part];
    assign buf_cur   = buf_idx_reg[op.part];
    assign cnt_inc   = cnt_cur + 1'b1;
    assign pad_dst   = {1'b1, end_flag_reg};

    // The emitter keeps no state of its own: the partition count tells how far
    // a padding run has got, so the head entry stays queued until it is done.
    always_comb
    begin
        op_pop        = 1'b0;
        emit          = 1'b0;
        cnt_we        = 1'b0;
        edge_we       = 1'b0;
        kind_next     = KIND_EDGE;
        part_next     = OUT_PART_W'(op.part);
        src_word_next = {1'b0, op.src};
        dst_word_next = {1'b0, op.dst};
        count_next    = cnt_inc;
        last_next     = 1'b1;
        if (op_valid && slot_free)
        begin
            unique case (op.op)
                OP_BAD_DST:
                begin
                    emit       = 1'b1;
                    op_pop     = 1'b1;
                    kind_next  = KIND_BAD_DST;
                    part_next  = '0;
                    count_next = '0;
                end
                OP_FLUSH:
                begin
                    if (cnt_cur == '0)
                    begin
                        op_pop = 1'b1;
                    end
                    else
                    begin
                        emit          = 1'b1;
                        cnt_we        = 1'b1;
                        kind_next     = KIND_TERM;
                        src_word_next = {1'b1, src_cur};
                        dst_word_next = pad_dst;
                        last_next     = (cnt_inc[ALIGN_W-1:0] == '0);
                        op_pop        = last_next;
                    end
                end
                OP_EDGE:
                begin
                    emit   = 1'b1;
                    cnt_we = 1'b1;
                    if ((op.src_buf != buf_cur) && (cnt_cur[ALIGN_W-1:0] != '0))
                    begin
                        kind_next     = KIND_ALIGN;
                        src_word_next = {1'b0, src_cur};
                        dst_word_next = pad_dst;
                        last_next     = 1'b0;
                    end
                    else
                    begin
                        edge_we = 1'b1;
                        op_pop  = 1'b1;
                    end
                end
                default:
                begin
                    op_pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_flag_reg  <= END_FLAG_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TOTAL_PARTS; i++)
            begin
                cnt_reg[i]      <= '0;
                last_src_reg[i] <= '0;
                buf_idx_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                end_flag_reg <= cfg_wdata;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cnt_we)
            begin
                cnt_reg[op.part] <= cnt_inc;
            end
            if (edge_we)
            begin
                last_src_reg[op.part] <= op.src;
                buf_idx_reg[op.part]  <= op.src_buf;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg     <= kind_next;
            part_reg     <= part_next;
            src_word_reg <= src_word_next;
            dst_word_reg <= dst_word_next;
            count_reg    <= count_next;
            last_reg     <= last_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign kind          = kind_reg;
    assign partition     = part_reg;
    assign edge_src_word = src_word_reg;
    assign edge_dst_word = dst_word_reg;
    assign edge_count    = count_reg;
    assign last          = last_reg;

endmodule

FILE: src/edge_partition_binner_padded_top.sv
// ----------------------------------------------------------------------------
// edge_partition_binner_padded_top
// Bins source-ordered edges into partitions with alignment and terminator pads.
// ----------------------------------------------------------------------------
//  channel   direction  tdata (low bit up)                               tuser
//  s_axis    in         src_vertex 31, dst_vertex 31, flush_partition 4  command
//  m_axis    out        partition 4, edge_src_word 32, edge_dst_word 32,
//                       edge_count 32 (zero padded to 104)               kind
//  cfg       in         cfg_wdata = end_flag, written when cfg_we is high
//
//  An accepted word is written into the queue, and its first result is loaded
//  into the output register of the back once the output slot is free. The back
//  emits one result word per cycle while the output is not stalled, so a plain
//  edge yields one word, a padded edge up to seven pads more, a flush up to eight.
//  Reset clears the partition table at once and sets end_flag to all ones.
//  The two-entry queue lets the input run on while the output is stalled, until full.
// ----------------------------------------------------------------------------
module edge_partition_binner_padded_top
    import epb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // src_vertex[30:0], dst_vertex[61:31], flush_partition[65:62], zero fill
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // command[0]
    input  logic [0:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // partition[3:0], edge_src_word[35:4], edge_dst_word[67:36],
    // edge_count[99:68], zero fill
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // kind[1:0]
    output logic [1:0]           m_axis_tuser,
    output logic                 m_axis_tlast,
    input  logic                 cfg_we,
    input  logic [VERTEX_W-1:0]  cfg_wdata
);

    logic                  push_valid;
    logic                  push_ready;
    bin_op_t               push_data;
    logic                  op_valid;
    logic                  op_pop;
    bin_op_t               op;
    kind_t                 kind;
    logic [OUT_PART_W-1:0] partition;
    logic [WORD_W-1:0]     edge_src_word;
    logic [WORD_W-1:0]     edge_dst_word;
    logic [WORD_W-1:0]     edge_count;

    epb_front u_front (
        .s_valid         (s_axis_tvalid),
        .s_ready         (s_axis_tready),
        .command         (s_axis_tuser[0]),
        .src_vertex      (s_axis_tdata[30:0]),
        .dst_vertex      (s_axis_tdata[61:31]),
        .flush_partition (s_axis_tdata[65:62]),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_data       (push_data)
    );

    epb_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (op_valid),
        .pop        (op_pop),
        .pop_data   (op)
    );

    epb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .op_valid      (op_valid),
        .op_pop        (op_pop),
        .op            (op),
        .m_valid       (m_axis_tvalid),
        .m_ready       (m_axis_tready),
        .kind          (kind),
        .partition     (partition),
        .edge_src_word (edge_src_word),
        .edge_dst_word (edge_dst_word),
        .edge_count    (edge_count),
        .last          (m_axis_tlast)
    );

    assign m_axis_tuser = kind;
    assign m_axis_tdata = {4'b0, edge_count, edge_dst_word, edge_src_word, partition};

    // An out-of-range destination always yields a single, final word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_BAD_DST)) |-> m_axis_tlast)
        else $error("out-of-range result without tlast");

    // Alignment pads are always followed by the real edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_ALIGN)) |-> !m_axis_tlast)
        else $error("alignment pad marked as last");

    // A flush ends exactly on an aligned count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_TERM)) |->
        (m_axis_tlast == (m_axis_tdata[70:68] == 3'b000)))
        else $error("terminator run not ending on an aligned count");

    // Pads carry the end flag with its top bit set.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && ((m_axis_tuser == KIND_ALIGN) || (m_axis_tuser == KIND_TERM)))
        |-> m_axis_tdata[67])
        else $error("pad without top bit in destination word");

endmodule
